[src/skt_pkg.sv]
// shared types, constants and helpers for the sorted key timestamp table
package skt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int CMD_W        = 3;
    localparam int KEY_IN_W     = 32;
    localparam int KEY_W        = 31;
    localparam int TIME_W       = 32;
    localparam int STATUS_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_DUMP   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_EXIT   = 3'd5,
        CMD_BAD6   = 3'd6,
        CMD_BAD7   = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_GENERAL   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_INVALID   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SEARCH_END,
        S_INS_RD,
        S_INS_WR,
        S_INS_NEW,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_END,
        S_RESP,
        S_DUMP_HDR,
        S_DUMP_RD,
        S_DUMP_EMIT
    } state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SINGLE,
        EMIT_HEADER,
        EMIT_ENTRY
    } emit_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load_in;
        idx_op_t idx_op;
        cnt_op_t cnt_op;
        logic    present_clr;
        logic    present_cmp;
        logic    latch_status;
        logic    latch_pos;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_new;
        emit_t   emit;
    } ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic positive;
        logic act_ok;
        logic idx_at_count;
        logic idx_at_pos;
        logic idx_last;
        logic rd_ge;
        logic count_zero;
        logic out_free;
    } dp_stat_t;

    // status of a single-result command, decided before the table changes
    function automatic status_t single_status(
        input cmd_t cmd,
        input logic positive,
        input logic present,
        input logic full,
        input logic empty
    );
        status_t st;
        st = ST_OK;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (!positive)
                    st = ST_GENERAL;
                else if (present)
                    st = ST_DUPLICATE;
                else if (full)
                    st = ST_FULL;
                else
                    st = ST_OK;
            end
            CMD_DELETE, CMD_FIND:
            begin
                if (!positive)
                    st = ST_GENERAL;
                else if (!present)
                    st = ST_NOT_FOUND;
                else
                    st = ST_OK;
            end
            CMD_DUMP:
                st = empty ? ST_NO_DATA : ST_OK;
            CMD_CLEAR, CMD_EXIT:
                st = ST_OK;
            default:
                st = ST_INVALID;
        endcase
        return st;
    endfunction

endpackage

[src/skt_req_if.sv]
// request channel: command, key and current time with valid/ready
interface skt_req_if;
    logic                                valid;
    logic                                ready;
    logic [skt_pkg::CMD_W-1:0]           command;
    logic signed [skt_pkg::KEY_IN_W-1:0] key;
    logic [skt_pkg::TIME_W-1:0]          now_time;

    modport source (output valid, output command, output key, output now_time, input ready);
    modport sink (input valid, input command, input key, input now_time, output ready);
endinterface

[src/skt_rsp_if.sv]
// response channel: one result item with valid/ready
interface skt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [skt_pkg::KEY_W-1:0]    echo_key;
    logic                         is_entry;
    logic [skt_pkg::KEY_W-1:0]    entry_key;
    logic [skt_pkg::TIME_W-1:0]   entry_time;
    logic                         last;

    modport source (output valid, output status, output echo_key, output is_entry,
                    output entry_key, output entry_time, output last, input ready);
    modport sink (input valid, input status, input echo_key, input is_entry,
                  input entry_key, input entry_time, input last, output ready);
endinterface

[src/skt_datapath.sv]
// datapath: command registers, sorted pair memory, walk index and result register
module skt_datapath #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  skt_pkg::ctl_t                       ctl,
    output skt_pkg::dp_stat_t                   stat,
    input  logic                                in_valid,
    input  logic [skt_pkg::CMD_W-1:0]           in_command,
    input  logic signed [skt_pkg::KEY_IN_W-1:0] in_key,
    input  logic [skt_pkg::TIME_W-1:0]          in_now_time,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [skt_pkg::STATUS_W-1:0]        out_status,
    output logic [skt_pkg::KEY_W-1:0]           out_echo_key,
    output logic                                out_is_entry,
    output logic [skt_pkg::KEY_W-1:0]           out_entry_key,
    output logic [skt_pkg::TIME_W-1:0]          out_entry_time,
    output logic                                out_last
);
    import skt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = KEY_W + TIME_W;

    // pair memory, key in the upper bits
    logic [WW-1:0] mem [CAPACITY];

    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              positive_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     pos_reg;
    logic              present_reg;
    status_t           stat_reg;
    logic [WW-1:0]     rd_data_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [KEY_W-1:0]  out_echo_reg;
    logic              out_is_entry_reg;
    logic [KEY_W-1:0]  out_entry_key_reg;
    logic [TIME_W-1:0] out_entry_time_reg;
    logic              out_last_reg;

    logic [CW-1:0]     idx_plus;
    logic [CW-1:0]     idx_minus;
    logic [AW-1:0]     rd_addr;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_time;
    logic              full;
    logic              empty;
    status_t           cur_status;
    logic              out_free;
    logic              out_load;
    logic              echo_cmd;

    assign idx_plus  = CW'(idx_reg + 1'b1);
    assign idx_minus = CW'(idx_reg - 1'b1);
    assign rd_key    = rd_data_reg[WW-1 -: KEY_W];
    assign rd_time   = rd_data_reg[TIME_W-1:0];
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign cur_status = single_status(cmd_reg, positive_reg, present_reg, full, empty);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (ctl.emit != EMIT_NONE) && out_free;
    assign echo_cmd  = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_DELETE)
                       || (cmd_reg == CMD_FIND);

    // read address select
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_PREV: rd_addr = idx_minus[AW-1:0];
            RD_NEXT: rd_addr = idx_plus[AW-1:0];
            default: rd_addr = idx_reg[AW-1:0];
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[idx_reg[AW-1:0]] <= ctl.wr_new ? {key_reg, time_reg} : rd_data_reg;
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // captured item fields
    always_ff @(posedge clk)
    begin
        if (ctl.load_in && in_valid)
        begin
            cmd_reg      <= cmd_t'(in_command);
            key_reg      <= in_key[KEY_W-1:0];
            positive_reg <= (in_key != '0) && !in_key[KEY_IN_W-1];
            time_reg     <= in_now_time;
        end
        if (ctl.latch_status)
            stat_reg <= cur_status;
        if (ctl.latch_pos)
            pos_reg <= idx_reg;
    end

    // count, walk index and search result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            present_reg <= 1'b0;
        end
        else
        begin
            case (ctl.cnt_op)
                CNT_CLEAR: count_reg <= '0;
                CNT_INC:   count_reg <= CW'(count_reg + 1'b1);
                CNT_DEC:   count_reg <= CW'(count_reg - 1'b1);
                default:   count_reg <= count_reg;
            endcase
            case (ctl.idx_op)
                IDX_ZERO:  idx_reg <= '0;
                IDX_INC:   idx_reg <= idx_plus;
                IDX_DEC:   idx_reg <= idx_minus;
                IDX_COUNT: idx_reg <= count_reg;
                default:   idx_reg <= idx_reg;
            endcase
            if (ctl.present_clr)
                present_reg <= 1'b0;
            else if (ctl.present_cmp)
                present_reg <= (rd_key == key_reg);
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            case (ctl.emit)
                EMIT_SINGLE:
                begin
                    out_status_reg     <= stat_reg;
                    out_echo_reg       <= (stat_reg == ST_OK && echo_cmd) ? key_reg : '0;
                    out_is_entry_reg   <= 1'b0;
                    out_entry_key_reg  <= '0;
                    out_entry_time_reg <= '0;
                    out_last_reg       <= 1'b1;
                end
                EMIT_ENTRY:
                begin
                    out_status_reg     <= ST_OK;
                    out_echo_reg       <= '0;
                    out_is_entry_reg   <= 1'b1;
                    out_entry_key_reg  <= rd_key;
                    out_entry_time_reg <= rd_time;
                    out_last_reg       <= (idx_plus == count_reg);
                end
                default:
                begin
                    out_status_reg     <= ST_OK;
                    out_echo_reg       <= '0;
                    out_is_entry_reg   <= 1'b0;
                    out_entry_key_reg  <= '0;
                    out_entry_time_reg <= '0;
                    out_last_reg       <= 1'b0;
                end
            endcase
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.positive     = positive_reg;
        stat.act_ok       = (cur_status == ST_OK);
        stat.idx_at_count = (idx_reg == count_reg);
        stat.idx_at_pos   = (idx_reg == pos_reg);
        stat.idx_last     = (idx_plus == count_reg);
        stat.rd_ge        = (rd_key >= key_reg);
        stat.count_zero   = empty;
        stat.out_free     = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_echo_key   = out_echo_reg;
    assign out_is_entry   = out_is_entry_reg;
    assign out_entry_key  = out_entry_key_reg;
    assign out_entry_time = out_entry_time_reg;
    assign out_last       = out_last_reg;

endmodule

[src/skt_controller.sv]
// controller: sequences search, shift, dump and result emission
module skt_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  skt_pkg::dp_stat_t stat,
    output skt_pkg::ctl_t     ctl
);
    import skt_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic search_cmd;

    assign search_cmd = (stat.cmd == CMD_INSERT) || (stat.cmd == CMD_DELETE)
                        || (stat.cmd == CMD_FIND);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                if (search_cmd)
                    state_next = stat.positive ? S_SEARCH_RD : S_RESP;
                else if (stat.cmd == CMD_DUMP)
                    state_next = stat.count_zero ? S_RESP : S_DUMP_HDR;
                else
                    state_next = S_RESP;
            end
            S_SEARCH_RD:
                state_next = stat.idx_at_count ? S_SEARCH_END : S_SEARCH_CMP;
            S_SEARCH_CMP:
                state_next = stat.rd_ge ? S_SEARCH_END : S_SEARCH_RD;
            S_SEARCH_END:
            begin
                if (stat.act_ok && stat.cmd == CMD_INSERT)
                    state_next = S_INS_RD;
                else if (stat.act_ok && stat.cmd == CMD_DELETE)
                    state_next = S_DEL_RD;
                else
                    state_next = S_RESP;
            end
            S_INS_RD:
                state_next = stat.idx_at_pos ? S_INS_NEW : S_INS_WR;
            S_INS_WR:
                state_next = S_INS_RD;
            S_INS_NEW:
                state_next = S_RESP;
            S_DEL_RD:
                state_next = stat.idx_last ? S_DEL_END : S_DEL_WR;
            S_DEL_WR:
                state_next = S_DEL_RD;
            S_DEL_END:
                state_next = S_RESP;
            S_RESP:
                if (stat.out_free)
                    state_next = S_IDLE;
            S_DUMP_HDR:
                if (stat.out_free)
                    state_next = S_DUMP_RD;
            S_DUMP_RD:
                state_next = S_DUMP_EMIT;
            S_DUMP_EMIT:
                if (stat.out_free)
                    state_next = stat.idx_last ? S_IDLE : S_DUMP_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        in_ready         = 1'b0;
        ctl.load_in      = 1'b0;
        ctl.idx_op       = IDX_HOLD;
        ctl.cnt_op       = CNT_HOLD;
        ctl.present_clr  = 1'b0;
        ctl.present_cmp  = 1'b0;
        ctl.latch_status = 1'b0;
        ctl.latch_pos    = 1'b0;
        ctl.rd_en        = 1'b0;
        ctl.rd_sel       = RD_IDX;
        ctl.wr_en        = 1'b0;
        ctl.wr_new       = 1'b0;
        ctl.emit         = EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.load_in = 1'b1;
            end
            S_DECODE:
            begin
                ctl.idx_op       = IDX_ZERO;
                ctl.present_clr  = 1'b1;
                ctl.latch_status = 1'b1;
                if (stat.cmd == CMD_CLEAR)
                    ctl.cnt_op = CNT_CLEAR;
            end
            S_SEARCH_RD:
            begin
                if (stat.idx_at_count)
                    ctl.present_clr = 1'b1;
                else
                    ctl.rd_en = 1'b1;
            end
            S_SEARCH_CMP:
            begin
                if (stat.rd_ge)
                    ctl.present_cmp = 1'b1;
                else
                    ctl.idx_op = IDX_INC;
            end
            S_SEARCH_END:
            begin
                ctl.latch_status = 1'b1;
                ctl.latch_pos    = 1'b1;
                if (stat.cmd == CMD_INSERT)
                    ctl.idx_op = IDX_COUNT;
            end
            S_INS_RD:
            begin
                if (!stat.idx_at_pos)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_PREV;
                end
            end
            S_INS_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.idx_op = IDX_DEC;
            end
            S_INS_NEW:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_new = 1'b1;
                ctl.cnt_op = CNT_INC;
            end
            S_DEL_RD:
            begin
                if (!stat.idx_last)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                end
            end
            S_DEL_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.idx_op = IDX_INC;
            end
            S_DEL_END:
                ctl.cnt_op = CNT_DEC;
            S_RESP:
                ctl.emit = EMIT_SINGLE;
            S_DUMP_HDR:
                ctl.emit = EMIT_HEADER;
            S_DUMP_RD:
                ctl.rd_en = 1'b1;
            S_DUMP_EMIT:
            begin
                ctl.emit = EMIT_ENTRY;
                if (stat.out_free)
                    ctl.idx_op = IDX_INC;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/sorted_key_timestamp_table.sv]
// Sorted key/timestamp table: one command item in, one or more result items out.
// Non-positive keys, clear, exit, bad codes and the dump header are answered without a table walk;
// find first compares slots in order up from the lowest key until one is not below the key,
// insert/delete then shift slots one at a time; dump reads and emits the entries one by one.
// One command item at a time: the next is accepted only once its last result is registered.
// Reset empties the table (entry count to zero); stored pairs are not cleared.
module sorted_key_timestamp_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    skt_req_if.sink    req,
    skt_rsp_if.source  rsp
);
    import skt_pkg::*;

    ctl_t     ctl;
    dp_stat_t stat;
    logic     in_ready;

    assign req.ready = in_ready;

    // sequencing
    skt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // storage and result register
    skt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .in_valid       (req.valid),
        .in_command     (req.command),
        .in_key         (req.key),
        .in_now_time    (req.now_time),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_echo_key   (rsp.echo_key),
        .out_is_entry   (rsp.is_entry),
        .out_entry_key  (rsp.entry_key),
        .out_entry_time (rsp.entry_time),
        .out_last       (rsp.last)
    );

endmodule

[tb/skt_table_checker.sv]
// checker: predicts the answers of the sorted key table and compares every result item
module skt_table_checker #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    skt_req_if   req,
    skt_rsp_if   rsp,
    output int   fail_count,
    output int   pending_count,
    output int   checked_count,
    output int   full_answers
);
    import skt_pkg::*;

    // one stored pair of the table
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
    } pair_t;

    // one result item as the block should send it
    typedef struct packed {
        status_t           status;
        logic [KEY_W-1:0]  echo_key;
        logic              is_entry;
        logic [KEY_W-1:0]  entry_key;
        logic [TIME_W-1:0] entry_time;
        logic              last;
    } answer_t;

    // predicted table contents, kept in ascending key order
    pair_t   rows[$];
    // answers still owed by the block, oldest first
    answer_t awaited[$];

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic answer_t single_answer(input status_t st, input logic [KEY_W-1:0] echo);
        answer_t a;
        a          = '0;
        a.status   = st;
        a.echo_key = echo;
        a.last     = 1'b1;
        return a;
    endfunction

    // queue one owed answer behind the others
    task automatic owe_answer(input answer_t a);
        awaited = {awaited, a};
    endtask

    // work out the answers of one command item and update the table
    task automatic predict_answers(
        input cmd_t                cmd,
        input logic [KEY_IN_W-1:0] raw,
        input logic [TIME_W-1:0]   now
    );
        logic             positive;
        logic [KEY_W-1:0] k;
        int               pos;
        logic             present;
        pair_t            fresh;
        answer_t          a;
        positive = (raw != '0) && !raw[KEY_IN_W-1];
        k        = raw[KEY_W-1:0];
        pos      = 0;
        while (pos < rows.size() && rows[pos].key < k)
            pos++;
        present = (pos < rows.size()) && (rows[pos].key == k);
        case (cmd)
            CMD_INSERT:
            begin
                if (!positive)
                    owe_answer(single_answer(ST_GENERAL, '0));
                else if (present)
                    owe_answer(single_answer(ST_DUPLICATE, '0));
                else if (rows.size() >= CAPACITY)
                begin
                    owe_answer(single_answer(ST_FULL, '0));
                    full_answers++;
                end
                else
                begin
                    fresh.key   = k;
                    fresh.stamp = now;
                    if (pos == rows.size())
                        rows = {rows, fresh};
                    else
                        rows.insert(pos, fresh);
                    owe_answer(single_answer(ST_OK, k));
                end
            end
            CMD_DELETE:
            begin
                if (!positive)
                    owe_answer(single_answer(ST_GENERAL, '0));
                else if (!present)
                    owe_answer(single_answer(ST_NOT_FOUND, '0));
                else
                begin
                    rows.delete(pos);
                    owe_answer(single_answer(ST_OK, k));
                end
            end
            CMD_FIND:
            begin
                if (!positive)
                    owe_answer(single_answer(ST_GENERAL, '0));
                else if (!present)
                    owe_answer(single_answer(ST_NOT_FOUND, '0));
                else
                    owe_answer(single_answer(ST_OK, k));
            end
            CMD_DUMP:
            begin
                if (rows.size() == 0)
                    owe_answer(single_answer(ST_NO_DATA, '0));
                else
                begin
                    // header, then every pair in key order with the final one marked
                    a      = single_answer(ST_OK, '0);
                    a.last = 1'b0;
                    owe_answer(a);
                    for (int i = 0; i < rows.size(); i++)
                    begin
                        a.is_entry   = 1'b1;
                        a.entry_key  = rows[i].key;
                        a.entry_time = rows[i].stamp;
                        a.last       = (i == rows.size() - 1);
                        owe_answer(a);
                    end
                end
            end
            CMD_CLEAR:
            begin
                rows.delete();
                owe_answer(single_answer(ST_OK, '0));
            end
            CMD_EXIT:
                owe_answer(single_answer(ST_OK, '0));
            default:
                owe_answer(single_answer(ST_INVALID, '0));
        endcase
    endtask

    // compare the item on the result channel with the oldest answer owed
    task automatic check_answer();
        answer_t want;
        checked_count++;
        if (awaited.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing expected (status %0d)",
                                      checked_count, rsp.status));
            return;
        end
        want = awaited.pop_front();
        if (rsp.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      checked_count, rsp.status, want.status));
        if (rsp.echo_key !== want.echo_key)
            report_mismatch($sformatf("result %0d echo_key %0h, want %0h",
                                      checked_count, rsp.echo_key, want.echo_key));
        if (rsp.is_entry !== want.is_entry)
            report_mismatch($sformatf("result %0d is_entry %b, want %b",
                                      checked_count, rsp.is_entry, want.is_entry));
        if (rsp.entry_key !== want.entry_key)
            report_mismatch($sformatf("result %0d entry_key %0h, want %0h",
                                      checked_count, rsp.entry_key, want.entry_key));
        if (rsp.entry_time !== want.entry_time)
            report_mismatch($sformatf("result %0d entry_time %0h, want %0h",
                                      checked_count, rsp.entry_time, want.entry_time));
        if (rsp.last !== want.last)
            report_mismatch($sformatf("result %0d last %b, want %b",
                                      checked_count, rsp.last, want.last));
    endtask

    // watch both channels at each rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rows.delete();
            awaited.delete();
            pending_count = 0;
        end
        else
        begin
            // a result item leaves the block
            if (rsp.valid && rsp.ready)
                check_answer();
            // a command item enters the block
            if (req.valid && req.ready)
                predict_answers(cmd_t'(req.command), req.key, req.now_time);
            pending_count = awaited.size();
        end
    end

endmodule

[tb/testbench.sv]
// testbench top: clock, reset, command stimulus, result back-pressure and verdict
module testbench;
    import skt_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int KEY_POOL     = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 3_000_000;

    logic clk;
    logic rst_n;
    logic calm;
    logic hold_rsp;
    logic sender_gaps;
    logic stall_mode;
    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   full_answers;
    int   sent_count;
    int   cmd_sent[8];

    skt_req_if req();
    skt_rsp_if rsp();

    sorted_key_timestamp_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    skt_table_checker #(
        .CAPACITY(CAPACITY)
    ) table_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .checked_count(checked_count),
        .full_answers (full_answers)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

    // offer one command item and wait until the block takes it
    task automatic send_item(
        input cmd_t                cmd,
        input logic [KEY_IN_W-1:0] key,
        input logic [TIME_W-1:0]   stamp
    );
        req.valid    <= 1'b1;
        req.command  <= cmd;
        req.key      <= key;
        req.now_time <= stamp;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent_count++;
        cmd_sent[cmd]++;
    endtask

    // drop valid for a while, with junk on the payload
    task automatic idle_sender(input int cycles);
        req.valid <= 1'b0;
        req.key   <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // send, then maybe leave a gap
    task automatic issue_command(
        input cmd_t                cmd,
        input logic [KEY_IN_W-1:0] key,
        input logic [TIME_W-1:0]   stamp
    );
        send_item(cmd, key, stamp);
        if (!calm && sender_gaps && $urandom_range(0, 2) == 0)
            idle_sender($urandom_range(1, 19));
    endtask

    // stop sending until every owed result has come back
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        @(posedge clk);
    endtask

    // keys mostly from a small pool so that hits, duplicates and a full table occur
    function automatic logic [KEY_IN_W-1:0] rand_key();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, KEY_POOL);
        else if (pick < 85)
            return {1'b0, 31'($urandom)};
        else if (pick < 90)
            return '0;
        else if (pick < 95)
            return $urandom | 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic cmd_t pick_command();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return CMD_INSERT;
        if (roll < 60)
            return CMD_DELETE;
        if (roll < 78)
            return CMD_FIND;
        if (roll < 86)
            return CMD_DUMP;
        if (roll < 89)
            return CMD_CLEAR;
        if (roll < 93)
            return CMD_EXIT;
        if (roll < 97)
            return CMD_BAD6;
        return CMD_BAD7;
    endfunction

    // field extremes, every command and every error answer except a full table
    task automatic run_directed();
        issue_command(CMD_DUMP, 0, 0);
        issue_command(CMD_FIND, 5, 0);
        issue_command(CMD_DELETE, 5, 0);
        issue_command(CMD_INSERT, 0, 32'h1234_5678);
        issue_command(CMD_INSERT, 32'h8000_0000, 0);
        issue_command(CMD_INSERT, 32'hFFFF_FFFF, 0);
        issue_command(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue_command(CMD_INSERT, 1, 0);
        issue_command(CMD_INSERT, 1000, $urandom);
        issue_command(CMD_INSERT, 1, 32'hAAAA_5555);
        issue_command(CMD_FIND, 1000, 0);
        issue_command(CMD_FIND, -5, 0);
        issue_command(CMD_DELETE, 0, 0);
        issue_command(CMD_DUMP, 0, 0);
        issue_command(CMD_DELETE, 1, 0);
        issue_command(CMD_DELETE, 1, 0);
        issue_command(CMD_FIND, 32'h7FFF_FFFF, 0);
        issue_command(CMD_EXIT, 77, 0);
        issue_command(CMD_BAD6, 7, 0);
        issue_command(CMD_BAD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(CMD_CLEAR, 0, 0);
        issue_command(CMD_DUMP, 0, 0);
        issue_command(CMD_FIND, 1000, 0);
    endtask

    // random commands in stretches with and without sender gaps
    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 25 == 0)
                sender_gaps = ($urandom_range(0, 2) != 0);
            issue_command(pick_command(), rand_key(), $urandom);
        end
    endtask

    // fill the table, hit the full and duplicate answers, then dump into a stalled receiver
    task automatic run_pressure();
        int                  slot;
        logic [KEY_IN_W-1:0] kept_key;
        logic [KEY_IN_W-1:0] fill_key;
        kept_key = '0;
        wait_drained();
        issue_command(CMD_CLEAR, 0, 0);
        for (int i = 0; i < CAPACITY; i++)
        begin
            // spread slots over the top key bits, inserted out of order
            slot     = (i * 13) % CAPACITY;
            fill_key = {1'b0, 5'(slot), 26'($urandom_range(1, 2 ** 26 - 1))};
            if (i == 0)
                kept_key = fill_key;
            issue_command(CMD_INSERT, fill_key, $urandom);
        end
        issue_command(CMD_INSERT, 32'h7FFF_FFFF, $urandom);
        issue_command(CMD_INSERT, kept_key, $urandom);
        hold_rsp = 1'b1;
        issue_command(CMD_DUMP, 0, 0);
        for (int i = 0; i < 8; i++)
            issue_command(CMD_FIND, (i == 0) ? kept_key : rand_key(), 0);
        issue_command(CMD_DUMP, 0, 0);
    endtask

    // result side: random stall bursts, quiet stretches and one long hold-off
    initial
    begin
        rsp.ready  = 1'b0;
        stall_mode = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!calm && stall_mode && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                stall_mode = !stall_mode;
        end
    end

    // command side and verdict
    initial
    begin
        req.valid    = 1'b0;
        req.command  = CMD_EXIT;
        req.key      = '0;
        req.now_time = '0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        hold_rsp     = 1'b0;
        sender_gaps  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(210);
        run_pressure();
        run_random(210);
        // last part with no idling on either side
        calm = 1'b1;
        run_random(50);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d inserts, %0d deletes, %0d finds, %0d dumps",
                 sent_count, cmd_sent[CMD_INSERT], cmd_sent[CMD_DELETE],
                 cmd_sent[CMD_FIND], cmd_sent[CMD_DUMP]);
        $display("checked %0d result items, %0d inserts refused by a full table",
                 checked_count, full_answers);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
src/skt_pkg.sv
src/skt_req_if.sv
src/skt_rsp_if.sv
src/skt_datapath.sv
src/skt_controller.sv
src/sorted_key_timestamp_table.sv
tb/skt_table_checker.sv
tb/testbench.sv
